FILE: rtl/core/isd_pkg.sv
`timescale 1ns / 1ps

package isd_pkg;

   // fixed field widths of the request and response words
   localparam int MASK_W  = 8;
   localparam int KEY_W   = 8;
   localparam int SLOT_W  = 3;
   localparam int SPACE_W = 16;
   localparam int CMD_W   = 2;
   localparam int MODE_W  = 2;

   // slot indices on the ports reach at most this many slots
   localparam int PORT_SLOTS = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CHOOSE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SIMULATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd2;

   // mode register codes
   localparam logic [MODE_W-1:0] MODE_RR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LU  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KR  = 2'd2;

   // character constants for the key range method
   localparam logic [KEY_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [KEY_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [KEY_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [KEY_W-1:0] CASE_OFFSET  = 8'd32;

   // sequencer to scan datapath control
   typedef struct packed {
      logic              start;   // latch a new word
      logic              step;    // read data of slot idx is present
      logic [SLOT_W-1:0] idx;     // slot being evaluated
      logic              commit;  // result leaves for the output register
   } scan_ctl_type;

endpackage

FILE: rtl/core/isd_space_mem.sv
`timescale 1ns / 1ps

module isd_space_mem
   import isd_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [SPACE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [SPACE_W-1:0] rd_data
);

   logic [SPACE_W-1:0] space_ff [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [SPACE_W-1:0] rd_data_ff;
   logic               rd_vld_ff;

   // storage array, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         space_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= space_ff[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   // written flags, an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/isd_scan.sv
`timescale 1ns / 1ps

module isd_scan
   import isd_pkg::*;
#(
   parameter int SLOT_N  = 8,
   parameter int IDX_W   = 3,
   parameter int LETTERS = 26
) (
   input  logic               clock,
   input  logic               reset,
   input  scan_ctl_type       ctl,
   input  logic [CMD_W-1:0]   cmd,
   input  logic [MASK_W-1:0]  alive_mask,
   input  logic [KEY_W-1:0]   key_char,
   input  logic [MODE_W-1:0]  mode,
   input  logic [SPACE_W-1:0] rd_data,
   output logic               res_valid,
   output logic [SLOT_W-1:0]  res_slot
);

   localparam int LTR_W = (LETTERS > 1) ? $clog2(LETTERS) : 1;
   localparam int TH_W  = $clog2(LETTERS + SLOT_N) + 1;
   localparam int CNT_W = $clog2(SLOT_N + 1);

   // letters per alive slot, ceil(LETTERS / count), built at elaboration
   logic [TH_W-1:0] per_tab [SLOT_N+1];
   assign per_tab[0] = '0;
   for (genvar c = 1; c <= SLOT_N; c++) begin : g_per
      localparam int PER_C = (LETTERS + c - 1) / c;
      assign per_tab[c] = TH_W'(PER_C);
   end

   logic [CMD_W-1:0]   cmd_ff,  cmd_in;
   logic [SLOT_N-1:0]  mask_ff, mask_in;
   logic [LTR_W-1:0]   ltr_ff,  ltr_in;
   logic               ltr_ok_ff, ltr_ok_in;
   logic [TH_W-1:0]    per_ff,  per_in;
   logic [TH_W-1:0]    thr_ff,  thr_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  best_ff, best_in;
   logic [SPACE_W-1:0] best_val_ff, best_val_in;
   logic               hi_found_ff, hi_found_in;
   logic [SLOT_W-1:0]  hi_ff, hi_in;
   logic               lo_found_ff, lo_found_in;
   logic [SLOT_W-1:0]  lo_ff, lo_in;
   logic [SLOT_W-1:0]  last_ff, last_in;
   logic               first_ff, first_in;

   logic [KEY_W-1:0]   fold;
   logic [KEY_W-1:0]   diff;
   logic [CNT_W-1:0]   cnt;
   logic               alive_now;
   logic               pick_valid;
   logic [SLOT_W-1:0]  pick_slot;

   // key folding and alive count for a new word
   always_comb begin
      if (key_char >= CHAR_UPPER_A && key_char <= CHAR_UPPER_Z) begin
         fold = key_char + CASE_OFFSET;
      end else begin
         fold = key_char;
      end
      diff = fold - CHAR_LOWER_A;
      cnt  = '0;
      for (int i = 0; i < SLOT_N; i++) begin
         cnt = cnt + CNT_W'(alive_mask[i]);
      end
   end

   assign alive_now = mask_ff[ctl.idx[IDX_W-1:0]];

   // per-slot accumulate, one slot per step
   always_comb begin
      cmd_in      = cmd_ff;
      mask_in     = mask_ff;
      ltr_in      = ltr_ff;
      ltr_ok_in   = ltr_ok_ff;
      per_in      = per_ff;
      thr_in      = thr_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_val_in = best_val_ff;
      hi_found_in = hi_found_ff;
      hi_in       = hi_ff;
      lo_found_in = lo_found_ff;
      lo_in       = lo_ff;
      last_in     = last_ff;
      first_in    = first_ff;

      if (ctl.start) begin
         cmd_in      = cmd;
         mask_in     = alive_mask[SLOT_N-1:0];
         ltr_in      = diff[LTR_W-1:0];
         ltr_ok_in   = (fold >= CHAR_LOWER_A) &&
                       ({1'b0, fold} < ({1'b0, CHAR_LOWER_A} + 9'(LETTERS)));
         per_in      = per_tab[cnt];
         thr_in      = per_tab[cnt];
         found_in    = 1'b0;
         hi_found_in = 1'b0;
         lo_found_in = 1'b0;
      end else if (ctl.step && alive_now) begin
         case (mode)
            MODE_RR: begin
               if (!lo_found_ff) begin
                  lo_found_in = 1'b1;
                  lo_in       = ctl.idx;
               end
               if (!first_ff && !hi_found_ff && ctl.idx > last_ff) begin
                  hi_found_in = 1'b1;
                  hi_in       = ctl.idx;
               end
            end
            MODE_LU: begin
               if (!found_ff || rd_data < best_val_ff) begin
                  found_in    = 1'b1;
                  best_in     = ctl.idx;
                  best_val_in = rd_data;
               end
            end
            MODE_KR: begin
               // the k-th alive slot, counted from zero, holds letters below (k + 1) * per
               if (!found_ff && TH_W'(ltr_ff) < thr_ff) begin
                  found_in = 1'b1;
                  best_in  = ctl.idx;
               end
               thr_in = thr_ff + per_ff;
            end
            default: begin
            end
         endcase
      end

      // round-robin pointer moves only on a committed choice
      if (ctl.commit && cmd_ff == CMD_CHOOSE && mode == MODE_RR && pick_valid) begin
         last_in  = pick_slot;
         first_in = 1'b0;
      end
   end

   // final choice from the accumulators
   always_comb begin
      pick_valid = 1'b0;
      pick_slot  = '0;
      case (mode)
         MODE_RR: begin
            pick_valid = hi_found_ff || lo_found_ff;
            pick_slot  = hi_found_ff ? hi_ff : lo_ff;
         end
         MODE_LU: begin
            pick_valid = found_ff;
            pick_slot  = best_ff;
         end
         MODE_KR: begin
            pick_valid = found_ff && ltr_ok_ff;
            pick_slot  = best_ff;
         end
         default: begin
            pick_valid = 1'b0;
         end
      endcase
      if (cmd_ff != CMD_CHOOSE && cmd_ff != CMD_SIMULATE) begin
         pick_valid = 1'b0;
      end
      if (!pick_valid) begin
         pick_slot = '0;
      end
   end

   assign res_valid = pick_valid;
   assign res_slot  = pick_slot;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff      <= CMD_UPDATE;
         found_ff    <= 1'b0;
         hi_found_ff <= 1'b0;
         lo_found_ff <= 1'b0;
         last_ff     <= '0;
         first_ff    <= 1'b1;
      end else begin
         cmd_ff      <= cmd_in;
         found_ff    <= found_in;
         hi_found_ff <= hi_found_in;
         lo_found_ff <= lo_found_in;
         last_ff     <= last_in;
         first_ff    <= first_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      ltr_ff      <= ltr_in;
      ltr_ok_ff   <= ltr_ok_in;
      per_ff      <= per_in;
      thr_ff      <= thr_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
   end

endmodule

FILE: rtl/core/instance_distribution_selector.sv
`timescale 1ns / 1ps

// Slot selector: picks one of up to eight storage slots for a key among the
// alive slots, by round robin, least space used (lowest slot on a tie) or key
// range by first letter, as set by the mode register. A choose word commits a
// round-robin pick, a simulate word answers without moving the pointer, and an
// update word writes one slot's space count. Every request word yields exactly
// one response word. Space counts sit in a small one-port-read memory; a
// choose or simulate word walks it one slot per cycle and then passes the last
// and finish steps before its response is loaded; an update word, an unused
// code or any word in the unused mode goes from acceptance straight to the
// finish step. A new request is taken once the previous response is in the
// output register. The mode register may be written only while no request is
// in flight.

module instance_distribution_selector
   import isd_pkg::*;
#(
   parameter int SLOTS   = 8,
   parameter int LETTERS = 26
) (
   input  logic              clock,
   input  logic              reset,
   // request: tdata = alive_mask[7:0], key_first_char[15:8], slot[18:16],
   // space_used[34:19], zero pad; tuser = command
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,
   input  logic [CMD_W-1:0]  req_tuser,
   // response: tdata = chosen_slot[2:0], zero pad; tuser = choice_valid
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser,
   // mode register
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data
);

   localparam int SLOT_N = (SLOTS < PORT_SLOTS) ? SLOTS : PORT_SLOTS;
   localparam int IDX_W  = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_LAST = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               step_ff;
   logic [IDX_W-1:0]   step_idx_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_choice_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   logic [MASK_W-1:0]  f_alive;
   logic [KEY_W-1:0]   f_key;
   logic [SLOT_W-1:0]  f_slot;
   logic [SPACE_W-1:0] f_space;

   logic               accept;
   logic               need_scan;
   logic               out_free;
   logic               load_rsp;
   logic               wr_en;
   logic [SPACE_W-1:0] rd_data;
   logic               res_valid;
   logic [SLOT_W-1:0]  res_slot;
   scan_ctl_type       ctl;

   // request word fields
   assign f_alive = req_tdata[7:0];
   assign f_key   = req_tdata[15:8];
   assign f_slot  = req_tdata[18:16];
   assign f_space = req_tdata[34:19];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign need_scan  = (req_tuser == CMD_CHOOSE || req_tuser == CMD_SIMULATE) &&
                       (mode_ff == MODE_RR || mode_ff == MODE_LU || mode_ff == MODE_KR);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_rsp   = (state_ff == ST_FIN) && out_free;
   assign wr_en      = accept && req_tuser == CMD_UPDATE &&
                       ({1'b0, f_slot} < 4'(SLOT_N));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_idx_in = '0;
               state_in  = need_scan ? ST_SCAN : ST_FIN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == IDX_W'(SLOT_N - 1)) begin
               state_in = ST_LAST;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RR;
         step_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      step_idx_ff <= rd_idx_ff;
      if (load_rsp) begin
         rsp_choice_ff <= res_valid;
         rsp_slot_ff   <= res_slot;
      end
   end

   // scan control, read data of a slot arrives in the cycle after its address
   always_comb begin
      ctl.start  = accept;
      ctl.step   = step_ff;
      ctl.idx    = SLOT_W'(step_idx_ff);
      ctl.commit = load_rsp;
   end

   // update words write here at acceptance, scan reads come later, so no
   // read and write of the same entry ever share a cycle
   isd_space_mem #(
      .DEPTH (SLOT_N),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (f_slot[IDX_W-1:0]),
      .wr_data (f_space),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   isd_scan #(
      .SLOT_N  (SLOT_N),
      .IDX_W   (IDX_W),
      .LETTERS (LETTERS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cmd        (req_tuser),
      .alive_mask (f_alive),
      .key_char   (f_key),
      .mode       (mode_ff),
      .rd_data    (rd_data),
      .res_valid  (res_valid),
      .res_slot   (res_slot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_choice_ff;
   assign rsp_tdata  = {5'b0, rsp_slot_ff};

   // a taken request closes the input until its response is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while a word is in flight");

   // a refused choice reports slot zero
   a_no_choice_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 8'd0))
      else $error("slot reported without a choice");

   // a chosen slot lies within the configured slots
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> ({1'b0, rsp_tdata[2:0]} < 4'(SLOT_N)))
      else $error("chosen slot out of range");

   // the last scan step is always followed by the finish step
   a_load_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |=> (state_ff == ST_FIN))
      else $error("scan did not end in the finish step");

endmodule
